// ----- src/edge_offset_round_join_core_defines.svh -----
// ----------------------------------------------------------------------------
// Edge offset round join: shared assertion macros
// Clocked checks with a synchronous active-high reset as the disable.
// ----------------------------------------------------------------------------
`ifndef EDGE_OFFSET_ROUND_JOIN_CORE_DEFINES_SVH
`define EDGE_OFFSET_ROUND_JOIN_CORE_DEFINES_SVH

// same-cycle implication
`define EORJ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EORJ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/eorj_pkg.sv -----
// ----------------------------------------------------------------------------
// Edge offset round join package
// Shared widths, angle constants, arctangent table and queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eorj_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int CORDIC_STEPS_DEF = 24;

   localparam int DIFF_W = 33;   // vertex difference
   localparam int VEC_W  = 45;   // vectoring datapath
   localparam int SC_W   = 34;   // sine/cosine datapath
   localparam int MUL_W  = 66;   // offset times Q30 product
   localparam int SUM_W  = 38;   // shifted coordinate before saturation
   localparam int DIV_STEPS = 33;

   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic signed [SC_W-1:0] CORDIC_KQ30 = 34'sd652032874;

   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0};

   localparam logic CSR_IDX_OFFSET   = 1'b0;
   localparam logic CSR_IDX_SEGMENTS = 1'b1;

   typedef struct packed {
      logic signed [31:0]       fx;
      logic signed [31:0]       fy;
      logic signed [31:0]       cx;
      logic signed [31:0]       cy;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] ndx;
      logic signed [DIFF_W-1:0] ndy;
      logic                     degen;
   } entry_type;

endpackage

// ----- src/edge_offset_round_join_core.sv -----
// Sequence: a zero-length edge emits its first and corner points without any CORDIC work.
// Otherwise the request is accepted, then two vectoring passes (setup, normalize, rotate),
// turn and segment setup, a restoring divide on the arc path, then a sine/cosine CORDIC pass,
// offset multiply and output per point. Throughput: one item at a time in the point generator;
// a new item is taken only when the sequencer is idle, as the CORDIC and multiplier are shared.
// Reset: synchronous, active high; registers return to offset 1.0 and 16 segments.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Edge offset round join core
// Offsets a polygon edge and emits a round join arc at convex corners.
// ----------------------------------------------------------------------------
module edge_offset_round_join_core #(
   parameter int COORD_WIDTH  = eorj_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = eorj_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_corner_x,
   input  logic signed [31:0] req_corner_y,
   input  logic signed [31:0] req_following_x,
   input  logic signed [31:0] req_following_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_is_arc_point,
   output logic               rsp_degenerate,
   output logic               rsp_last_point
);
   import eorj_pkg::*;

   logic signed [31:0] offset_ff, offset_in;
   logic [5:0]         segments_ff, segments_in;
   logic               csr_write;

   entry_type          f2q_data, q2b_data;
   logic               f2q_valid, f2q_ready, q2b_valid, q2b_ready;
   logic [31:0]        pt_x, pt_y;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      offset_in   = offset_ff;
      segments_in = segments_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IDX_OFFSET:   offset_in   = csr_data;
            CSR_IDX_SEGMENTS: segments_in = csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= 32'sd65536;
         segments_ff <= 6'd16;
      end else begin
         offset_ff   <= offset_in;
         segments_ff <= segments_in;
      end
   end

   eorj_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_corner_x    (req_corner_x),
      .req_corner_y    (req_corner_y),
      .req_following_x (req_following_x),
      .req_following_y (req_following_y),
      .push_valid      (f2q_valid),
      .push_ready      (f2q_ready),
      .push_data       (f2q_data)
   );

   eorj_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f2q_valid),
      .push_ready (f2q_ready),
      .push_data  (f2q_data),
      .pop_valid  (q2b_valid),
      .pop_ready  (q2b_ready),
      .pop_data   (q2b_data)
   );

   eorj_back #(
      .COORD_WIDTH  (COORD_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg_offset       (offset_ff),
      .cfg_segments     (segments_ff),
      .in_valid         (q2b_valid),
      .in_ready         (q2b_ready),
      .in_data          (q2b_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (pt_x),
      .rsp_point_y      (pt_y),
      .rsp_is_arc_point (rsp_is_arc_point),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_last_point   (rsp_last_point)
   );

   assign rsp_point_x = $signed(pt_x);
   assign rsp_point_y = $signed(pt_y);

endmodule

// ----- src/eorj_front.sv -----
// ----------------------------------------------------------------------------
// Edge offset round join: front end
// Accepts vertex triples, forms edge vectors and flags zero-length edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eorj_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [31:0]   req_first_x,
   input  logic signed [31:0]   req_first_y,
   input  logic signed [31:0]   req_corner_x,
   input  logic signed [31:0]   req_corner_y,
   input  logic signed [31:0]   req_following_x,
   input  logic signed [31:0]   req_following_y,
   output logic                 push_valid,
   input  logic                 push_ready,
   output eorj_pkg::entry_type  push_data
);
   import eorj_pkg::*;

   logic      stage_valid_ff, stage_valid_in;
   entry_type entry_ff, entry_in;
   entry_type fresh;
   logic      req_take;

   always_comb begin
      fresh.fx  = req_first_x;
      fresh.fy  = req_first_y;
      fresh.cx  = req_corner_x;
      fresh.cy  = req_corner_y;
      fresh.dx  = DIFF_W'(req_corner_x) - DIFF_W'(req_first_x);
      fresh.dy  = DIFF_W'(req_corner_y) - DIFF_W'(req_first_y);
      fresh.ndx = DIFF_W'(req_following_x) - DIFF_W'(req_corner_x);
      fresh.ndy = DIFF_W'(req_following_y) - DIFF_W'(req_corner_y);
      fresh.degen = ((fresh.dx == '0) && (fresh.dy == '0)) ||
                    ((fresh.ndx == '0) && (fresh.ndy == '0));
   end

   assign req_ready  = !stage_valid_ff || push_ready;
   assign req_take   = req_valid && req_ready;
   assign push_valid = stage_valid_ff;
   assign push_data  = entry_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      entry_in       = entry_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
         entry_in       = fresh;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ----- src/eorj_queue.sv -----
// ----------------------------------------------------------------------------
// Edge offset round join: decoupling queue
// Two-entry queue between the front end and the point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eorj_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  eorj_pkg::entry_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output eorj_pkg::entry_type  pop_data
);
   import eorj_pkg::*;

   localparam int DEPTH = 2;

   entry_type  slot_ff [0:DEPTH-1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/eorj_back.sv -----
// ----------------------------------------------------------------------------
// Edge offset round join: point generator
// Sequencer with a shared vectoring CORDIC, sine/cosine CORDIC, divider
// and multiplier; emits the offset points through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "edge_offset_round_join_core_defines.svh"

module eorj_back #(
   parameter int COORD_WIDTH  = eorj_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = eorj_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   cfg_offset,
   input  logic [5:0]           cfg_segments,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  eorj_pkg::entry_type  in_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_point_x,
   output logic [31:0]          rsp_point_y,
   output logic                 rsp_is_arc_point,
   output logic                 rsp_degenerate,
   output logic                 rsp_last_point
);
   import eorj_pkg::*;

   localparam int CNT_W = ($clog2(CORDIC_STEPS) > 5) ? $clog2(CORDIC_STEPS) : 5;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
   localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
   localparam logic signed [MUL_W-1:0] RND_BIAS = MUL_W'(64'sd1 <<< 29);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_VSETUP = 4'd1;
   localparam logic [3:0] S_VNORM  = 4'd2;
   localparam logic [3:0] S_VROT   = 4'd3;
   localparam logic [3:0] S_TURN   = 4'd4;
   localparam logic [3:0] S_SEGS   = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_SCINIT = 4'd7;
   localparam logic [3:0] S_SCROT  = 4'd8;
   localparam logic [3:0] S_MUL0   = 4'd9;
   localparam logic [3:0] S_MUL1   = 4'd10;
   localparam logic [3:0] S_MUL2   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   localparam logic [2:0] K_DEG0   = 3'd0;
   localparam logic [2:0] K_DEG1   = 3'd1;
   localparam logic [2:0] K_FIRST  = 3'd2;
   localparam logic [2:0] K_CORNER = 3'd3;
   localparam logic [2:0] K_ARC    = 3'd4;

   function automatic logic [31:0] sat_fn(input logic signed [SUM_W-1:0] v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [3:0]               state_ff, state_in;
   entry_type                ent_ff, ent_in;
   logic                     sel_ff, sel_in;
   logic signed [VEC_W-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0]              vz_ff, vz_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [31:0]              ac_ff, ac_in, an_ff, an_in;
   logic                     arc_path_ff, arc_path_in;
   logic [32:0]              sweep_ff, sweep_in;
   logic [5:0]               segs_ff, segs_in;
   logic [32:0]              q0_ff, q0_in;
   logic [5:0]               r0_ff, r0_in;
   logic [5:0]               div_cnt_ff, div_cnt_in;
   logic [32:0]              q_ff, q_in;
   logic [5:0]               r_ff, r_in;
   logic [5:0]               i_ff, i_in;
   logic [31:0]              ang_ff, ang_in;
   logic [2:0]               kind_ff, kind_in;
   logic signed [SC_W-1:0]   sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic                     fold_ff, fold_in;
   logic signed [MUL_W-1:0]  mul_ff, mul_in;
   logic [31:0]              pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic                     out_valid_ff, out_valid_in;
   logic [31:0]              out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                     out_arc_ff, out_arc_in;
   logic                     out_deg_ff, out_deg_in;
   logic                     out_last_ff, out_last_in;

   // combinational helpers
   logic [4:0]               tap;
   logic [31:0]              atan_k;
   logic signed [VEC_W-1:0]  vxs, vys, v_ax, v_ay;
   logic [VEC_W-1:0]         mag_or;
   logic signed [DIFF_W-1:0] src_x, src_y;
   logic signed [SC_W-1:0]   sxs, sys, s_fin, negc_fin, mul_op;
   logic signed [MUL_W-1:0]  rnd_full;
   logic signed [SUM_W-1:0]  pt_sum;
   logic signed [31:0]       base_x, base_y;
   logic [32:0]              turn;
   logic [38:0]              seg_prod;
   logic [6:0]               seg_hi, div_sh, r_sum;
   logic                     div_bit, r_wrap;
   logic [32:0]              q_next;
   logic [5:0]               r_next;
   logic [31:0]              psi_fold;
   logic                     psi_fold_bit;
   logic                     out_free, is_last;

   assign tap    = cnt_ff[4:0];
   assign atan_k = ATAN_TAB[tap];
   assign vxs    = vx_ff >>> tap;
   assign vys    = vy_ff >>> tap;
   assign sxs    = sx_ff >>> tap;
   assign sys    = sy_ff >>> tap;
   assign src_x  = sel_ff ? ent_ff.ndx : ent_ff.dx;
   assign src_y  = sel_ff ? ent_ff.ndy : ent_ff.dy;
   assign v_ax   = vx_ff;
   assign v_ay   = (vy_ff < 0) ? -vy_ff : vy_ff;
   assign mag_or = v_ax | v_ay;

   assign s_fin    = fold_ff ? -sy_ff : sy_ff;
   assign negc_fin = fold_ff ? sx_ff : -sx_ff;
   assign mul_op   = (state_ff == S_MUL0) ? s_fin : negc_fin;
   assign mul_in   = MUL_W'(cfg_offset) * MUL_W'(mul_op);
   assign rnd_full = (mul_ff + RND_BIAS) >>> 30;
   assign base_x   = (kind_ff == K_FIRST) ? ent_ff.fx : ent_ff.cx;
   assign base_y   = (kind_ff == K_FIRST) ? ent_ff.fy : ent_ff.cy;
   assign pt_sum   = (state_ff == S_MUL1) ? SUM_W'(base_x) + SUM_W'(rnd_full)
                                          : SUM_W'(base_y) + SUM_W'(rnd_full);

   assign turn     = (an_ff > ac_ff) ? {1'b0, an_ff} - {1'b0, ac_ff}
                                     : {1'b0, an_ff} + 33'h1_0000_0000 - {1'b0, ac_ff};
   assign seg_prod = 39'(cfg_segments) * 39'(sweep_ff);
   assign seg_hi   = seg_prod[38:32];

   assign div_sh  = {r0_ff, q0_ff[32]};
   assign div_bit = (div_sh >= {1'b0, segs_ff});

   assign r_sum  = {1'b0, r_ff} + {1'b0, r0_ff};
   assign r_wrap = (r_sum >= {1'b0, segs_ff});
   assign q_next = q_ff + q0_ff + 33'(r_wrap);
   assign r_next = r_wrap ? 6'(r_sum - {1'b0, segs_ff}) : r_sum[5:0];

   assign psi_fold_bit = ang_ff[31] ^ ang_ff[30];   // bit 31 of angle plus a quarter turn
   assign psi_fold     = psi_fold_bit ? ang_ff - HALF_TURN : ang_ff;

   assign out_free = !out_valid_ff || rsp_ready;
   assign is_last  = (kind_ff == K_DEG1) || (kind_ff == K_CORNER) ||
                     ((kind_ff == K_ARC) && (i_ff == segs_ff));
   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      ent_in      = ent_ff;
      sel_in      = sel_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      vz_in       = vz_ff;
      cnt_in      = cnt_ff;
      ac_in       = ac_ff;
      an_in       = an_ff;
      arc_path_in = arc_path_ff;
      sweep_in    = sweep_ff;
      segs_in     = segs_ff;
      q0_in       = q0_ff;
      r0_in       = r0_ff;
      div_cnt_in  = div_cnt_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      i_in        = i_ff;
      ang_in      = ang_ff;
      kind_in     = kind_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      sz_in       = sz_ff;
      fold_in     = fold_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      out_valid_in = (out_valid_ff && !rsp_ready);
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_arc_in  = out_arc_ff;
      out_deg_in  = out_deg_ff;
      out_last_in = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               ent_in = in_data;
               sel_in = 1'b0;
               if (in_data.degen) begin
                  pt_x_in  = sat_fn(SUM_W'(in_data.fx));
                  pt_y_in  = sat_fn(SUM_W'(in_data.fy));
                  kind_in  = K_DEG0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_VSETUP;
               end
            end
         end
         S_VSETUP: begin
            if (src_x < 0) begin
               vx_in = -VEC_W'(src_x);
               vy_in = -VEC_W'(src_y);
               vz_in = HALF_TURN;
            end else begin
               vx_in = VEC_W'(src_x);
               vy_in = VEC_W'(src_y);
               vz_in = '0;
            end
            state_in = S_VNORM;
         end
         S_VNORM: begin
            // scale up until the larger magnitude reaches bit 40
            if (mag_or[VEC_W-1:32] == '0) begin
               vx_in = vx_ff <<< 8;
               vy_in = vy_ff <<< 8;
            end else if (mag_or[VEC_W-1:40] == '0) begin
               vx_in = vx_ff <<< 1;
               vy_in = vy_ff <<< 1;
            end else begin
               cnt_in   = '0;
               state_in = S_VROT;
            end
         end
         S_VROT: begin
            if (vy_ff > 0) begin
               vx_in = vx_ff + vys;
               vy_in = vy_ff - vxs;
               vz_in = vz_ff + atan_k;
            end else begin
               vx_in = vx_ff - vys;
               vy_in = vy_ff + vxs;
               vz_in = vz_ff - atan_k;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               if (!sel_ff) begin
                  ac_in    = vz_in;
                  sel_in   = 1'b1;
                  state_in = S_VSETUP;
               end else begin
                  an_in    = vz_in;
                  state_in = S_TURN;
               end
            end
         end
         S_TURN: begin
            arc_path_in = (turn < 33'h0_8000_0000);
            sweep_in    = (cfg_offset == '0) ? 33'h1_0000_0000 : turn;
            state_in    = S_SEGS;
         end
         S_SEGS: begin
            if (seg_hi == 7'd0) begin
               segs_in = 6'd1;
            end else if (seg_hi > 7'd62) begin
               segs_in = 6'd62;
            end else begin
               segs_in = seg_hi[5:0];
            end
            kind_in = K_FIRST;
            ang_in  = ac_ff;
            if (arc_path_ff) begin
               q0_in      = sweep_ff;
               r0_in      = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end else begin
               state_in   = S_SCINIT;
            end
         end
         S_DIV: begin
            // restoring divide: sweep / segs, quotient shifts into q0
            r0_in      = div_bit ? 6'(div_sh - {1'b0, segs_ff}) : div_sh[5:0];
            q0_in      = {q0_ff[31:0], div_bit};
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = S_SCINIT;
            end
         end
         S_SCINIT: begin
            fold_in  = psi_fold_bit;
            sx_in    = CORDIC_KQ30;
            sy_in    = '0;
            sz_in    = SC_W'($signed(psi_fold));
            cnt_in   = '0;
            state_in = S_SCROT;
         end
         S_SCROT: begin
            if (sz_ff >= 0) begin
               sx_in = sx_ff - sys;
               sy_in = sy_ff + sxs;
               sz_in = sz_ff - SC_W'(atan_k);
            end else begin
               sx_in = sx_ff + sys;
               sy_in = sy_ff - sxs;
               sz_in = sz_ff + SC_W'(atan_k);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            state_in = S_MUL1;
         end
         S_MUL1: begin
            pt_x_in  = sat_fn(pt_sum);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            pt_y_in  = sat_fn(pt_sum);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = pt_x_ff;
               out_y_in     = pt_y_ff;
               out_arc_in   = (kind_ff == K_ARC);
               out_deg_in   = (kind_ff == K_DEG0) || (kind_ff == K_DEG1);
               out_last_in  = is_last;
               if (is_last) begin
                  state_in = S_IDLE;
               end else if (kind_ff == K_DEG0) begin
                  pt_x_in = sat_fn(SUM_W'(ent_ff.cx));
                  pt_y_in = sat_fn(SUM_W'(ent_ff.cy));
                  kind_in = K_DEG1;
               end else if (kind_ff == K_FIRST) begin
                  kind_in  = arc_path_ff ? K_ARC : K_CORNER;
                  ang_in   = ac_ff;
                  i_in     = '0;
                  q_in     = '0;
                  r_in     = '0;
                  state_in = S_SCINIT;
               end else begin
                  // next arc point
                  i_in     = i_ff + 6'd1;
                  q_in     = q_next;
                  r_in     = r_next;
                  ang_in   = ac_ff + q_next[31:0];
                  state_in = S_SCINIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         kind_ff      <= K_DEG0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         kind_ff      <= kind_in;
      end
      ent_ff      <= ent_in;
      sel_ff      <= sel_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      cnt_ff      <= cnt_in;
      ac_ff       <= ac_in;
      an_ff       <= an_in;
      arc_path_ff <= arc_path_in;
      sweep_ff    <= sweep_in;
      segs_ff     <= segs_in;
      q0_ff       <= q0_in;
      r0_ff       <= r0_in;
      div_cnt_ff  <= div_cnt_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      i_ff        <= i_in;
      ang_ff      <= ang_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      fold_ff     <= fold_in;
      mul_ff      <= mul_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_arc_ff  <= out_arc_in;
      out_deg_ff  <= out_deg_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_point_x      = out_x_ff;
   assign rsp_point_y      = out_y_ff;
   assign rsp_is_arc_point = out_arc_ff;
   assign rsp_degenerate   = out_deg_ff;
   assign rsp_last_point   = out_last_ff;

   `EORJ_ASSERT_NOW(a_deg_not_arc, clock, reset, out_valid_ff && out_deg_ff, !out_arc_ff, "degenerate point flagged as arc")
   `EORJ_ASSERT_NOW(a_arc_index, clock, reset, (kind_ff == K_ARC) && (state_ff != S_IDLE), (i_ff <= segs_ff) && (r_ff < segs_ff), "arc index or remainder out of range")
   `EORJ_ASSERT_NOW(a_segs_range, clock, reset, state_ff == S_DIV, (segs_ff != 6'd0) && (segs_ff <= 6'd62), "arc segment count out of range")
   `EORJ_ASSERT_NEXT(a_last_idle, clock, reset, (state_ff == S_OUT) && out_free && is_last, state_ff == S_IDLE, "sequencer did not return idle after last point")

endmodule
